// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, held off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same, written as an overlapping implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/cbnec_pkg.sv -----
`timescale 1ns / 1ps

package cbnec_pkg;

	localparam int INDEX_BITS    = 24;
	localparam int CALLER_BITS   = 12;
	localparam int CALLEE_BITS   = INDEX_BITS - CALLER_BITS;
	localparam int ADDR_BITS     = 48;
	localparam int COUNT_BITS    = 64;

	// The bitmap is kept as rows of 2^ROW_BITS bits.
	localparam int ROW_BITS      = 6;
	localparam int ROW_WIDTH     = 1 << ROW_BITS;
	localparam int ROW_ADDR_BITS = INDEX_BITS - ROW_BITS;

	typedef struct packed {
		logic [ADDR_BITS-1:0] callee_address;
		logic [ADDR_BITS-1:0] caller_address;
	} event_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] map_index;
		logic                  first_visit;
		logic [COUNT_BITS-1:0] new_edge_total;
	} result_t;

endpackage

// ----- rtl/coverage_bitmap_new_edge_counter_unit.sv -----
`timescale 1ns / 1ps

// An accepted event is registered in stage 1 (vld_s1), then in result_valid_q and result_q.
// Throughput: one event per cycle unless stalled, set by one read-modify-write of a bitmap row.
// Reset: the count clears at once; the bitmap is then cleared by a sweep of
// 2^18 = 262144 rows, one row per cycle, during which event_stall stays high.
module coverage_bitmap_new_edge_counter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               event_valid,
	output logic               event_stall,
	input  cbnec_pkg::event_t  event_data,
	output logic               result_valid,
	input  logic               result_stall,
	output cbnec_pkg::result_t result_data
);

	logic                                   clear_busy_q;
	logic [cbnec_pkg::ROW_ADDR_BITS-1:0]    clear_addr_q;

	logic                                   accept;
	logic [cbnec_pkg::INDEX_BITS-1:0]       index_in;

	logic                                   vld_s1;
	logic [cbnec_pkg::INDEX_BITS-1:0]       index_s1;
	logic                                   adv_s1;
	logic [cbnec_pkg::ROW_WIDTH-1:0]        rd_row;
	logic [cbnec_pkg::ROW_WIDTH-1:0]        row_s1;
	logic [cbnec_pkg::ROW_WIDTH-1:0]        bit_mask;
	logic                                   first;
	logic [cbnec_pkg::COUNT_BITS-1:0]       count_next;

	logic                                   fwd_vld_q;
	logic [cbnec_pkg::ROW_ADDR_BITS-1:0]    fwd_addr_q;
	logic [cbnec_pkg::ROW_WIDTH-1:0]        fwd_data_q;

	logic                                   ram_we;
	logic [cbnec_pkg::ROW_ADDR_BITS-1:0]    ram_waddr;
	logic [cbnec_pkg::ROW_WIDTH-1:0]        ram_wdata;

	logic [cbnec_pkg::COUNT_BITS-1:0]       count_q;
	logic                                   result_valid_q;
	cbnec_pkg::result_t                     result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clear_addr_q <= '0;
		end else if (clear_busy_q) begin
			clear_addr_q <= clear_addr_q + 1'b1;
			if (&clear_addr_q) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	assign event_stall = clear_busy_q || (vld_s1 && !adv_s1);
	assign accept      = event_valid && !event_stall;
	assign index_in    = {event_data.callee_address[cbnec_pkg::CALLEE_BITS-1:0],
		event_data.caller_address[cbnec_pkg::CALLER_BITS-1:0]};

	cbnec_ram #(
		.ADDR_W(cbnec_pkg::ROW_ADDR_BITS),
		.DATA_W(cbnec_pkg::ROW_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(index_in[cbnec_pkg::INDEX_BITS-1:cbnec_pkg::ROW_BITS]),
		.rdata(rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			index_s1 <= index_in;
		end
	end

	assign adv_s1 = vld_s1 && (!result_valid_q || !result_stall);

	// The row was read at the same edge that wrote back the previous event, so
	// the memory may return the row from before that write; take the newer copy.
	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == index_s1[cbnec_pkg::INDEX_BITS-1:cbnec_pkg::ROW_BITS])) begin
			row_s1 = fwd_data_q;
		end else begin
			row_s1 = rd_row;
		end
	end

	assign bit_mask   = cbnec_pkg::ROW_WIDTH'(1) << index_s1[cbnec_pkg::ROW_BITS-1:0];
	assign first      = (row_s1 & bit_mask) == '0;
	assign count_next = count_q + cbnec_pkg::COUNT_BITS'(first);

	always_comb begin
		if (clear_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clear_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = adv_s1;
			ram_waddr = index_s1[cbnec_pkg::INDEX_BITS-1:cbnec_pkg::ROW_BITS];
			ram_wdata = row_s1 | bit_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (adv_s1) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fwd_addr_q <= index_s1[cbnec_pkg::INDEX_BITS-1:cbnec_pkg::ROW_BITS];
			fwd_data_q <= row_s1 | bit_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				count_q        <= count_next;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q.map_index      <= index_s1;
			result_q.first_visit    <= first;
			result_q.new_edge_total <= count_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

// ----- rtl/cbnec_ram.sv -----
`timescale 1ns / 1ps

module cbnec_ram #(
	parameter int ADDR_W = 18,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read returns the contents from before a write at the same edge.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/cbnec_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbnec_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               event_valid,
	input logic               event_stall,
	input logic               result_valid,
	input logic               result_stall,
	input cbnec_pkg::result_t result_data
);

	logic [cbnec_pkg::COUNT_BITS-1:0] total_q;
	logic [cbnec_pkg::COUNT_BITS-1:0] expect_total;

	// Total carried by the last result transfer; the count starts at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (result_valid && !result_stall) begin
			total_q <= result_data.new_edge_total;
		end
	end

	assign expect_total = total_q + cbnec_pkg::COUNT_BITS'(result_data.first_visit);

	`ASSERT_CLK(a_result_hold, (result_valid && result_stall) |=> (result_valid && $stable(result_data)), "stalled result changed")
	`ASSERT_IMPLY(a_total_step, result_valid && !result_stall, result_data.new_edge_total == expect_total, "count did not follow first visits")
	`ASSERT_IMPLY(a_fill_latency, $rose(result_valid), $past(event_valid && !event_stall, 2), "result appeared without an event two cycles before")

endmodule

bind coverage_bitmap_new_edge_counter_unit cbnec_checker u_cbnec_checker (.*);
